// File: sv/rfc_pkg.sv
// Shared types, constants and fixed-point helpers for the radial falloff curve.
package rfc_pkg;

    // Fixed-point format
    localparam int FB = 16;
    localparam int UW = FB + 1;          // holds values 0 .. ONE
    localparam int NI = 24 - FB;         // integer bits of the power exponent
    localparam int RW = FB + 5;          // square-root partial remainder
    localparam int XW = 2 * FB + 2;      // square-root radicand, even width

    // Pipeline geometry
    localparam int DIV_PER = 2;
    localparam int DIV_ST  = (FB + DIV_PER - 1) / DIV_PER;
    localparam int SQ_PER  = 6;
    localparam int SQ_SUB  = (FB + 1 + SQ_PER - 1) / SQ_PER;
    localparam int SQ_ST   = SQ_SUB + 1;
    localparam int PW_ST   = NI + FB * SQ_ST;

    typedef logic signed [31:0] fix_t;
    typedef logic [UW-1:0]      u_t;
    typedef logic [FB-1:0]      frac_t;
    typedef logic [RW-1:0]      rem_t;
    typedef logic [XW-1:0]      x_t;

    localparam fix_t ONE     = 32'sd1 <<< FB;
    localparam fix_t OUT_MAX = 32'sd8388607;
    localparam fix_t OUT_MIN = -32'sd8388608;

    // Curve modes
    localparam logic [3:0] MODE_NONE     = 4'd0;
    localparam logic [3:0] MODE_LINEAR   = 4'd1;
    localparam logic [3:0] MODE_SMOOTH   = 4'd2;
    localparam logic [3:0] MODE_QUINTIC  = 4'd3;
    localparam logic [3:0] MODE_EASE_IN  = 4'd4;
    localparam logic [3:0] MODE_EASE_OUT = 4'd5;
    localparam logic [3:0] MODE_IN_OUT   = 4'd6;
    localparam logic [3:0] MODE_POWER    = 4'd7;
    localparam logic [3:0] MODE_BEZIER   = 4'd8;

    // Register indexes
    localparam logic [2:0] REG_CURVE_MODE = 3'd0;
    localparam logic [2:0] REG_INNER      = 3'd1;
    localparam logic [2:0] REG_OUTER      = 3'd2;
    localparam logic [2:0] REG_EXPONENT   = 3'd3;
    localparam logic [2:0] REG_BEZ_ONE    = 3'd4;
    localparam logic [2:0] REG_BEZ_TWO    = 3'd5;
    localparam logic [2:0] REG_BEZ_THREE  = 3'd6;

    // Result selection carried with each sample
    localparam logic [1:0] SEL_CURVE = 2'd0;
    localparam logic [1:0] SEL_ONE   = 2'd1;
    localparam logic [1:0] SEL_ZERO  = 2'd2;

    typedef struct packed {
        logic        valid;
        logic [1:0]  sel;
        logic [33:0] rem;
        logic [32:0] den;
        frac_t       q;
    } div_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] sel;
        frac_t      t;
        u_t         r;
        u_t         base;
        u_t         s;
        rem_t       rem;
        u_t         root;
    } pw_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] sel;
        frac_t      t;
        u_t         pw;
        fix_t       a0;   // tt, then t3
        fix_t       a1;   // t*(6t-15)
        fix_t       a2;   // uu, then u3
        fix_t       a3;   // bb, then b3
        fix_t       a4;   // b01, then c0
        fix_t       a5;   // b12, then c1
        fix_t       a6;   // b23, then smoothstep
    } cv_t;

    // Product scaled back by ONE, rounded toward minus infinity
    function automatic fix_t fmul(input fix_t a, input fix_t b);
        logic signed [63:0] p;
        begin
            p = a * b;
            return fix_t'(p >>> FB);
        end
    endfunction

    function automatic fix_t fmix(input fix_t a, input fix_t b, input fix_t t);
        return a + fmul(b - a, t);
    endfunction

endpackage

// File: sv/radial_falloff_curve.sv
// Top level of the radial falloff curve: registers, divider, power chain and curve stages.
//
// Usage: one distance sample enters on the s_ channel (s_valid/s_ready), one weight
// leaves on the m_ channel (m_valid/m_ready) for every sample, in order. Configuration
// registers are written over cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. The user must write them only while no sample is in flight (unchecked).
// Throughput: one sample per cycle while the receiver does not stall. At 16 fraction bits
// the pipeline is the 8-stage radix-2 divider (two quotient bits per stage), the
// 8 square-and-multiply stages for the integer exponent and the 16 square roots of the
// fractional exponent, each three stages of up to six root bits and one multiply stage,
// followed by three curve stages.
// Reset (aresetn low, synchronous) empties the pipeline and loads the register defaults.
// When the receiver stalls the whole pipeline holds; s_ready then stays low until the
// waiting result is taken, and nothing is lost or repeated.
module radial_falloff_curve (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_sample_distance,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [23:0] m_falloff_weight,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    logic [3:0]          mode_reg;
    logic signed [31:0]  inner_reg;
    logic signed [31:0]  outer_reg;
    logic [23:0]         exp_reg;
    logic signed [19:0]  p1_reg;
    logic signed [19:0]  p2_reg;
    logic signed [19:0]  p3_reg;

    logic                en;
    logic                in_valid_reg;
    logic signed [31:0]  in_dist_reg;
    rfc_pkg::div_t       div_reg [0:rfc_pkg::DIV_ST];
    rfc_pkg::div_t       div_next;
    rfc_pkg::pw_t        pw_reg [0:rfc_pkg::PW_ST];
    rfc_pkg::cv_t        c1_reg, c1_next, c2_reg, c2_next;
    logic                out_valid_reg;
    logic signed [23:0]  out_reg;
    logic signed [23:0]  out_next;

    // Advance the whole pipeline unless the result waits
    assign en        = !out_valid_reg || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_falloff_weight = out_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= rfc_pkg::MODE_NONE;
            inner_reg <= 32'sd0;
            outer_reg <= 32'sd65536;
            exp_reg   <= 24'd131072;
            p1_reg    <= 20'sd0;
            p2_reg    <= 20'sd0;
            p3_reg    <= 20'sd0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rfc_pkg::REG_CURVE_MODE: mode_reg  <= cfg_data[3:0];
                rfc_pkg::REG_INNER:      inner_reg <= cfg_data;
                rfc_pkg::REG_OUTER:      outer_reg <= cfg_data;
                rfc_pkg::REG_EXPONENT:   exp_reg   <= cfg_data[23:0];
                rfc_pkg::REG_BEZ_ONE:    p1_reg    <= cfg_data[19:0];
                rfc_pkg::REG_BEZ_TWO:    p2_reg    <= cfg_data[19:0];
                rfc_pkg::REG_BEZ_THREE:  p3_reg    <= cfg_data[19:0];
                default: ;
            endcase
        end
    end

    // Capture the input transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_valid;
            in_dist_reg  <= s_sample_distance;
        end
    end

    // Classify the sample and form the division operands
    always_comb begin
        logic signed [32:0] diff;
        logic signed [32:0] span;
        diff = {in_dist_reg[31], in_dist_reg} - {inner_reg[31], inner_reg};
        span = {outer_reg[31], outer_reg} - {inner_reg[31], inner_reg};
        div_next.valid = in_valid_reg;
        div_next.rem   = {1'b0, diff};
        div_next.den   = span;
        div_next.q     = '0;
        if (mode_reg == rfc_pkg::MODE_NONE || mode_reg > rfc_pkg::MODE_BEZIER)
            div_next.sel = rfc_pkg::SEL_ONE;
        else if (in_dist_reg <= inner_reg)
            div_next.sel = rfc_pkg::SEL_ONE;
        else if (in_dist_reg >= outer_reg)
            div_next.sel = rfc_pkg::SEL_ZERO;
        else
            div_next.sel = rfc_pkg::SEL_CURVE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) div_reg[0].valid <= 1'b0;
        else if (en) div_reg[0] <= div_next;
    end

    // Restoring divider, two quotient bits per stage
    for (genvar i = 0; i < rfc_pkg::DIV_ST; i++) begin : g_div
        rfc_pkg::div_t nx;
        always_comb begin
            logic [33:0] sh;
            nx = div_reg[i];
            for (int j = 0; j < rfc_pkg::DIV_PER; j++) begin
                if (i * rfc_pkg::DIV_PER + j < rfc_pkg::FB) begin
                    sh = {nx.rem[32:0], 1'b0};
                    if (sh >= {1'b0, nx.den}) begin
                        nx.rem = sh - {1'b0, nx.den};
                        nx.q   = {nx.q[rfc_pkg::FB-2:0], 1'b1};
                    end else begin
                        nx.rem = sh;
                        nx.q   = {nx.q[rfc_pkg::FB-2:0], 1'b0};
                    end
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) div_reg[i+1].valid <= 1'b0;
            else if (en) div_reg[i+1] <= nx;
        end
    end

    // Load the power chain: r = ONE, base = s = u
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pw_reg[0].valid <= 1'b0;
        end else if (en) begin
            pw_reg[0].valid <= div_reg[rfc_pkg::DIV_ST].valid;
            pw_reg[0].sel   <= div_reg[rfc_pkg::DIV_ST].sel;
            pw_reg[0].t     <= div_reg[rfc_pkg::DIV_ST].q;
            pw_reg[0].r     <= rfc_pkg::u_t'(rfc_pkg::ONE);
            pw_reg[0].base  <= rfc_pkg::u_t'(rfc_pkg::ONE) -
                               rfc_pkg::u_t'(div_reg[rfc_pkg::DIV_ST].q);
            pw_reg[0].s     <= rfc_pkg::u_t'(rfc_pkg::ONE) -
                               rfc_pkg::u_t'(div_reg[rfc_pkg::DIV_ST].q);
            pw_reg[0].rem   <= '0;
            pw_reg[0].root  <= '0;
        end
    end

    // Power chain: square and multiply, then square roots for the fraction bits
    for (genvar i = 0; i < rfc_pkg::PW_ST; i++) begin : g_pw
        rfc_pkg::pw_t nx;
        if (i < rfc_pkg::NI) begin : g_int
            always_comb begin
                nx = pw_reg[i];
                if (exp_reg[rfc_pkg::FB + i])
                    nx.r = rfc_pkg::u_t'(rfc_pkg::fmul(rfc_pkg::fix_t'(pw_reg[i].r),
                                                       rfc_pkg::fix_t'(pw_reg[i].base)));
                nx.base = rfc_pkg::u_t'(rfc_pkg::fmul(rfc_pkg::fix_t'(pw_reg[i].base),
                                                      rfc_pkg::fix_t'(pw_reg[i].base)));
            end
        end else begin : g_frac
            localparam int F = (i - rfc_pkg::NI) / rfc_pkg::SQ_ST;
            localparam int G = (i - rfc_pkg::NI) % rfc_pkg::SQ_ST;
            localparam int K = rfc_pkg::FB - 1 - F;
            if (G < rfc_pkg::SQ_SUB) begin : g_root
                always_comb begin
                    rfc_pkg::rem_t rm;
                    rfc_pkg::rem_t r2;
                    rfc_pkg::rem_t tr;
                    rfc_pkg::u_t   rt;
                    rfc_pkg::x_t   x;
                    int            p;
                    nx = pw_reg[i];
                    x  = rfc_pkg::x_t'(pw_reg[i].s) << rfc_pkg::FB;
                    if (G == 0) begin
                        rm = '0;
                        rt = '0;
                    end else begin
                        rm = pw_reg[i].rem;
                        rt = pw_reg[i].root;
                    end
                    // One root bit per step, radicand pairs from the top
                    for (int j = 0; j < rfc_pkg::SQ_PER; j++) begin
                        if (G * rfc_pkg::SQ_PER + j <= rfc_pkg::FB) begin
                            p  = rfc_pkg::FB - (G * rfc_pkg::SQ_PER + j);
                            r2 = {rm[rfc_pkg::RW-3:0], x[2*p +: 2]};
                            tr = rfc_pkg::rem_t'({rt, 2'b01});
                            if (r2 >= tr) begin
                                rm = r2 - tr;
                                rt = {rt[rfc_pkg::UW-2:0], 1'b1};
                            end else begin
                                rm = r2;
                                rt = {rt[rfc_pkg::UW-2:0], 1'b0};
                            end
                        end
                    end
                    nx.rem  = rm;
                    nx.root = rt;
                end
            end else begin : g_mul
                always_comb begin
                    nx   = pw_reg[i];
                    nx.s = pw_reg[i].root;
                    if (exp_reg[K])
                        nx.r = rfc_pkg::u_t'(rfc_pkg::fmul(rfc_pkg::fix_t'(pw_reg[i].r),
                                                           rfc_pkg::fix_t'(pw_reg[i].root)));
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) pw_reg[i+1].valid <= 1'b0;
            else if (en) pw_reg[i+1] <= nx;
        end
    end

    // Curve stage one: squares, quintic inner product, first Bezier level
    always_comb begin
        rfc_pkg::fix_t t, u, b, p1, p2, p3;
        t  = rfc_pkg::fix_t'(pw_reg[rfc_pkg::PW_ST].t);
        u  = rfc_pkg::ONE - t;
        b  = 2 * rfc_pkg::ONE - 2 * t;
        p1 = rfc_pkg::fix_t'(p1_reg);
        p2 = rfc_pkg::fix_t'(p2_reg);
        p3 = rfc_pkg::fix_t'(p3_reg);
        c1_next.valid = pw_reg[rfc_pkg::PW_ST].valid;
        c1_next.sel   = pw_reg[rfc_pkg::PW_ST].sel;
        c1_next.t     = pw_reg[rfc_pkg::PW_ST].t;
        c1_next.pw    = pw_reg[rfc_pkg::PW_ST].r;
        c1_next.a0    = rfc_pkg::fmul(t, t);
        c1_next.a1    = rfc_pkg::fmul(t, 6 * t - 15 * rfc_pkg::ONE);
        c1_next.a2    = rfc_pkg::fmul(u, u);
        c1_next.a3    = rfc_pkg::fmul(b, b);
        c1_next.a4    = rfc_pkg::fmix(rfc_pkg::ONE, p1, t);
        c1_next.a5    = rfc_pkg::fmix(p1, p2, t);
        c1_next.a6    = rfc_pkg::fmix(p2, p3, t);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) c1_reg.valid <= 1'b0;
        else if (en) c1_reg <= c1_next;
    end

    // Curve stage two: cubes, smoothstep, second Bezier level
    always_comb begin
        rfc_pkg::fix_t t, u, b;
        t = rfc_pkg::fix_t'(c1_reg.t);
        u = rfc_pkg::ONE - t;
        b = 2 * rfc_pkg::ONE - 2 * t;
        c2_next    = c1_reg;
        c2_next.a0 = rfc_pkg::fmul(c1_reg.a0, t);
        c2_next.a2 = rfc_pkg::fmul(c1_reg.a2, u);
        c2_next.a3 = rfc_pkg::fmul(c1_reg.a3, b);
        c2_next.a4 = rfc_pkg::fmix(c1_reg.a4, c1_reg.a5, t);
        c2_next.a5 = rfc_pkg::fmix(c1_reg.a5, c1_reg.a6, t);
        c2_next.a6 = rfc_pkg::ONE - rfc_pkg::fmul(c1_reg.a0, 3 * rfc_pkg::ONE - 2 * t);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) c2_reg.valid <= 1'b0;
        else if (en) c2_reg <= c2_next;
    end

    // Curve stage three: pick the curve, override the ends, saturate
    always_comb begin
        rfc_pkg::fix_t t, w;
        t = rfc_pkg::fix_t'(c2_reg.t);
        case (mode_reg)
            rfc_pkg::MODE_LINEAR:   w = rfc_pkg::ONE - t;
            rfc_pkg::MODE_SMOOTH:   w = c2_reg.a6;
            rfc_pkg::MODE_QUINTIC:
                w = rfc_pkg::ONE - rfc_pkg::fmul(c2_reg.a0, c2_reg.a1 + 10 * rfc_pkg::ONE);
            rfc_pkg::MODE_EASE_IN:  w = rfc_pkg::ONE - c2_reg.a0;
            rfc_pkg::MODE_EASE_OUT: w = c2_reg.a2;
            rfc_pkg::MODE_IN_OUT:
                w = (t < (rfc_pkg::ONE >>> 1)) ? rfc_pkg::ONE - 4 * c2_reg.a0
                                               : c2_reg.a3 >>> 1;
            rfc_pkg::MODE_POWER:    w = rfc_pkg::fix_t'(c2_reg.pw);
            rfc_pkg::MODE_BEZIER:   w = rfc_pkg::fmix(c2_reg.a4, c2_reg.a5, t);
            default:                w = rfc_pkg::ONE;
        endcase
        if (c2_reg.sel == rfc_pkg::SEL_ONE)
            w = rfc_pkg::ONE;
        else if (c2_reg.sel == rfc_pkg::SEL_ZERO)
            w = '0;
        if (w > rfc_pkg::OUT_MAX)
            w = rfc_pkg::OUT_MAX;
        else if (w < rfc_pkg::OUT_MIN)
            w = rfc_pkg::OUT_MIN;
        out_next = w[23:0];
    end

    // Hold the result until the transaction completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= c2_reg.valid;
            out_reg       <= out_next;
        end
    end

    // Input is taken exactly when the output register can move
    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready does not follow the output stall");

    // A stalled sample in the last power stage is kept
    a_stall_keeps_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (!en && pw_reg[rfc_pkg::PW_ST].valid) |=> pw_reg[rfc_pkg::PW_ST].valid)
        else $error("sample lost in the power chain during a stall");

    // Mode none always yields one
    a_mode_none_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && mode_reg == rfc_pkg::MODE_NONE) |->
            (m_falloff_weight == 24'sd65536 <<< (rfc_pkg::FB - 16)))
        else $error("mode none produced a weight other than one");

endmodule
